FILE: hdl/tefh_pkg.sv
package tefh_pkg;

  // default geometry
  localparam int NUM_CHUNKS_DEF   = 256;
  localparam int CHUNK_BYTES_DEF  = 64;
  localparam int HEADER_BYTES_DEF = 32;

  // fixed field widths
  localparam int SIZE_W   = 16;
  localparam int INDEX_W  = 8;
  localparam int OFFSET_W = 14;
  localparam int HEAP_W   = 9;
  localparam int APB_W    = 32;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // register index
  localparam logic REG_HEAP_CHUNKS = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic               req_type;
    logic [SIZE_W-1:0]  size_bytes;
    logic               long_term;
    logic [INDEX_W-1:0] free_block;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] data_offset;
  } rsp_t;

  // one chunk entry of the heap map
  typedef struct packed {
    logic start;
    logic used;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN_UP,
    S_SCAN_DN,
    S_FCHK,
    S_FUP,
    S_FDN,
    S_WA,
    S_WB,
    S_RESP
  } state_t;

endpackage

FILE: hdl/tefh_mem.sv
module tefh_mem #(
  parameter int DEPTH = tefh_pkg::NUM_CHUNKS_DEF,
  parameter int AW    = $clog2(tefh_pkg::NUM_CHUNKS_DEF)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tefh_pkg::ent_t  wdata,
  input  logic [AW-1:0]   raddr,
  output tefh_pkg::ent_t  rdata
);

  tefh_pkg::ent_t mem [DEPTH];
  tefh_pkg::ent_t rdata_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tefh_div.sv
module tefh_div #(
  parameter int DW      = 17,
  parameter int DIVISOR = tefh_pkg::CHUNK_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  // scaled reciprocal, exact after truncation for every DW-bit dividend
  localparam int     SH    = DW + $clog2(DIVISOR);
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam int     MW    = DW + 2;
  localparam int     PW    = DW + MW;

  logic          done_r, done_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [PW-1:0] prod;

  // one multiply by the reciprocal, then drop the scale bits
  always_comb begin
    prod     = {{MW{1'b0}}, dividend} * {{DW{1'b0}}, MW'(RECIP)};
    quo_nxt  = DW'(prod >> SH);
    done_nxt = start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    if (start) begin
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/two_ended_first_fit_heap_core.sv
// First-fit heap manager over a chunk map held in one simple dual-port memory
// (a start bit and a used bit per chunk). An allocate works out its chunk count
// with a reciprocal multiply, then walks the map one chunk per cycle, upward
// from chunk 0 or downward from the heap end, and writes back in states S_WA
// and S_WB. A free walks from the freed block to its neighbors. A stalled
// result holds back the next one until it leaves. The single memory read port
// sets the pace of the walk. After reset and after each write of heap_chunks
// the whole map of NUM_CHUNKS entries is cleared, during which no request is
// taken.
module two_ended_first_fit_heap_core #(
  parameter int NUM_CHUNKS   = tefh_pkg::NUM_CHUNKS_DEF,
  parameter int CHUNK_BYTES  = tefh_pkg::CHUNK_BYTES_DEF,
  parameter int HEADER_BYTES = tefh_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tefh_pkg::req_t             in_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tefh_pkg::rsp_t             out_rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [0:0]                 paddr,
  input  logic [tefh_pkg::APB_W-1:0] pwdata,
  output logic [tefh_pkg::APB_W-1:0] prdata,
  output logic                       pready
);

  localparam int IW = $clog2(NUM_CHUNKS);
  localparam int HW = (IW + 1 > tefh_pkg::HEAP_W) ? IW + 1 : tefh_pkg::HEAP_W;
  localparam int DW = $clog2((1 << tefh_pkg::SIZE_W) + HEADER_BYTES + CHUNK_BYTES);
  localparam int HEAP_RST = (NUM_CHUNKS < 256) ? NUM_CHUNKS : 256;

  tefh_pkg::state_t state_r, state_nxt;
  logic [HW-1:0] heap_r, heap_nxt;
  logic [HW-1:0] clr_r, clr_nxt;
  logic [HW-1:0] q_r, q_nxt;
  logic [HW-1:0] b_r, b_nxt;
  logic [HW-1:0] e_r, e_nxt;
  logic [HW-1:0] fb_r, fb_nxt;
  logic          bused_r, bused_nxt;
  logic          long_r, long_nxt;
  logic          rtype_r, rtype_nxt;
  logic          wa_en_r, wa_en_nxt;
  logic [IW-1:0] wa_addr_r, wa_addr_nxt;
  tefh_pkg::ent_t wa_data_r, wa_data_nxt;
  logic [IW-1:0] wb_addr_r, wb_addr_nxt;
  tefh_pkg::ent_t wb_data_r, wb_data_nxt;
  tefh_pkg::status_t st_r, st_nxt;
  logic [HW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  tefh_pkg::rsp_t out_rsp_r, out_rsp_nxt;

  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  tefh_pkg::ent_t mem_wdata;
  logic [IW-1:0]  mem_raddr;
  tefh_pkg::ent_t mem_rdata;

  logic          div_start;
  logic [DW-1:0] div_dvd;
  logic          div_done;
  logic [DW-1:0] need;

  logic                  cfg_wr;
  logic [tefh_pkg::HEAP_W-1:0] cfg_val;
  logic [HW-1:0]         len;
  logic                  fit;
  logic [31:0]           off_full;

  tefh_mem #(.DEPTH(NUM_CHUNKS), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tefh_div #(.DW(DW), .DIVISOR(CHUNK_BYTES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .done     (div_done),
    .quotient (need)
  );

  // register port
  assign pready = 1'b1;
  assign prdata = tefh_pkg::APB_W'(heap_r);
  assign cfg_wr = psel && penable && pwrite && (paddr == tefh_pkg::REG_HEAP_CHUNKS);
  assign cfg_val = pwdata[tefh_pkg::HEAP_W-1:0];

  assign in_ready  = (state_r == tefh_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // chunk count of a request, rounded up
  assign div_dvd = DW'(HEADER_BYTES) + DW'(in_req.size_bytes) + DW'(CHUNK_BYTES - 1);

  // fit test of the block closing this cycle
  always_comb begin
    if (state_r == tefh_pkg::S_SCAN_DN) begin
      len = e_r - q_r;
      fit = !mem_rdata.used && (32'(len) >= 32'(need));
    end else begin
      len = q_r - b_r;
      fit = !bused_r && (32'(len) >= 32'(need));
    end
  end

  assign off_full = 32'(idx_r) * 32'(CHUNK_BYTES) + 32'(HEADER_BYTES);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    heap_nxt    = heap_r;
    clr_nxt     = clr_r;
    q_nxt       = q_r;
    b_nxt       = b_r;
    e_nxt       = e_r;
    fb_nxt      = fb_r;
    bused_nxt   = bused_r;
    long_nxt    = long_r;
    rtype_nxt   = rtype_r;
    wa_en_nxt   = wa_en_r;
    wa_addr_nxt = wa_addr_r;
    wa_data_nxt = wa_data_r;
    wb_addr_nxt = wb_addr_r;
    wb_data_nxt = wb_data_r;
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt = out_rsp_r;
    mem_we      = 1'b0;
    mem_waddr   = wb_addr_r;
    mem_wdata   = wb_data_r;
    mem_raddr   = IW'(q_r);
    div_start   = 1'b0;

    unique case (state_r)
      tefh_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(clr_r);
        mem_wdata = '{start: (clr_r == '0), used: 1'b0};
        if (clr_r == HW'(NUM_CHUNKS - 1)) begin
          state_nxt = tefh_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      tefh_pkg::S_IDLE: begin
        if (in_valid) begin
          rtype_nxt = in_req.req_type;
          long_nxt  = in_req.long_term;
          fb_nxt    = HW'(in_req.free_block);
          idx_nxt   = '0;
          st_nxt    = tefh_pkg::ST_OK;
          wa_en_nxt = 1'b0;
          if (in_req.req_type == tefh_pkg::REQ_ALLOC) begin
            div_start = 1'b1;
            state_nxt = tefh_pkg::S_DIV;
          end else if (HW'(in_req.free_block) >= heap_r) begin
            st_nxt    = tefh_pkg::ST_BAD_FREE;
            state_nxt = tefh_pkg::S_RESP;
          end else begin
            mem_raddr = IW'(in_req.free_block);
            state_nxt = tefh_pkg::S_FCHK;
          end
        end
      end
      tefh_pkg::S_DIV: begin
        if (div_done) begin
          if (long_r) begin
            q_nxt     = heap_r - 1'b1;
            e_nxt     = heap_r;
            mem_raddr = IW'(heap_r - 1'b1);
            state_nxt = tefh_pkg::S_SCAN_DN;
          end else begin
            q_nxt     = '0;
            b_nxt     = '0;
            mem_raddr = '0;
            state_nxt = tefh_pkg::S_SCAN_UP;
          end
        end
      end
      tefh_pkg::S_SCAN_UP: begin
        mem_raddr = IW'(q_r + 1'b1);
        q_nxt     = q_r + 1'b1;
        if ((q_r != '0) && (q_r == heap_r || mem_rdata.start) && fit) begin
          e_nxt     = q_r;
          wa_en_nxt = 32'(need) < 32'(len);
          wa_addr_nxt = IW'(32'(b_r) + 32'(need));
          wa_data_nxt = '{start: 1'b1, used: 1'b0};
          wb_addr_nxt = IW'(b_r);
          wb_data_nxt = '{start: 1'b1, used: 1'b1};
          idx_nxt   = b_r;
          state_nxt = tefh_pkg::S_WA;
        end else if (q_r == heap_r) begin
          st_nxt    = tefh_pkg::ST_NO_SPACE;
          state_nxt = tefh_pkg::S_RESP;
        end else if (mem_rdata.start) begin
          b_nxt     = q_r;
          bused_nxt = mem_rdata.used;
        end
      end
      tefh_pkg::S_SCAN_DN: begin
        mem_raddr = IW'(q_r - 1'b1);
        q_nxt     = q_r - 1'b1;
        if (mem_rdata.start && fit) begin
          wa_en_nxt = 32'(need) < 32'(len);
          wa_addr_nxt = IW'(32'(q_r) + 32'(need));
          wa_data_nxt = '{start: 1'b1, used: 1'b0};
          wb_addr_nxt = IW'(q_r);
          wb_data_nxt = '{start: 1'b1, used: 1'b1};
          idx_nxt   = q_r;
          state_nxt = tefh_pkg::S_WA;
        end else if (q_r == '0) begin
          st_nxt    = tefh_pkg::ST_NO_SPACE;
          state_nxt = tefh_pkg::S_RESP;
        end else if (mem_rdata.start) begin
          e_nxt = q_r;
        end
      end
      tefh_pkg::S_FCHK: begin
        wb_addr_nxt = IW'(fb_r);
        wb_data_nxt = '{start: 1'b1, used: 1'b0};
        if (!mem_rdata.start || !mem_rdata.used) begin
          st_nxt    = tefh_pkg::ST_BAD_FREE;
          state_nxt = tefh_pkg::S_RESP;
        end else begin
          q_nxt     = fb_r + 1'b1;
          mem_raddr = IW'(fb_r + 1'b1);
          state_nxt = tefh_pkg::S_FUP;
        end
      end
      tefh_pkg::S_FUP: begin
        mem_raddr = IW'(q_r + 1'b1);
        q_nxt     = q_r + 1'b1;
        if (q_r == heap_r || mem_rdata.start) begin
          // merge with a free block that follows
          wa_en_nxt   = (q_r != heap_r) && !mem_rdata.used;
          wa_addr_nxt = IW'(q_r);
          wa_data_nxt = '{start: 1'b0, used: 1'b0};
          if (fb_r == '0) begin
            state_nxt = tefh_pkg::S_WA;
          end else begin
            q_nxt     = fb_r - 1'b1;
            mem_raddr = IW'(fb_r - 1'b1);
            state_nxt = tefh_pkg::S_FDN;
          end
        end
      end
      tefh_pkg::S_FDN: begin
        mem_raddr = IW'(q_r - 1'b1);
        q_nxt     = q_r - 1'b1;
        if (mem_rdata.start) begin
          // merge into a free block before it
          wb_data_nxt = '{start: mem_rdata.used, used: 1'b0};
          state_nxt   = tefh_pkg::S_WA;
        end
      end
      tefh_pkg::S_WA: begin
        mem_we    = wa_en_r;
        mem_waddr = wa_addr_r;
        mem_wdata = wa_data_r;
        state_nxt = tefh_pkg::S_WB;
      end
      tefh_pkg::S_WB: begin
        mem_we    = 1'b1;
        state_nxt = tefh_pkg::S_RESP;
      end
      tefh_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.status      = st_r;
          out_rsp_nxt.block_index = tefh_pkg::INDEX_W'(idx_r);
          out_rsp_nxt.data_offset =
            (st_r == tefh_pkg::ST_OK && rtype_r == tefh_pkg::REQ_ALLOC) ?
            off_full[tefh_pkg::OFFSET_W-1:0] : '0;
          state_nxt = tefh_pkg::S_IDLE;
        end
      end
      default: state_nxt = tefh_pkg::S_IDLE;
    endcase

    // heap size write restarts the map
    if (cfg_wr) begin
      if (cfg_val == '0) begin
        heap_nxt = HW'(1);
      end else if (32'(cfg_val) > 32'(NUM_CHUNKS)) begin
        heap_nxt = HW'(NUM_CHUNKS);
      end else begin
        heap_nxt = HW'(cfg_val);
      end
      clr_nxt   = '0;
      state_nxt = tefh_pkg::S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tefh_pkg::S_CLEAR;
      heap_r      <= HW'(HEAP_RST);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      heap_r      <= heap_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_r       <= q_nxt;
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    fb_r      <= fb_nxt;
    bused_r   <= bused_nxt;
    long_r    <= long_nxt;
    rtype_r   <= rtype_nxt;
    wa_en_r   <= wa_en_nxt;
    wa_addr_r <= wa_addr_nxt;
    wa_data_r <= wa_data_nxt;
    wb_addr_r <= wb_addr_nxt;
    wb_data_r <= wb_data_nxt;
    st_r      <= st_nxt;
    idx_r     <= idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

FILE: hdl/tefh_chk.sv
module tefh_chk #(
  parameter int CHUNK_BYTES  = tefh_pkg::CHUNK_BYTES_DEF,
  parameter int HEADER_BYTES = tefh_pkg::HEADER_BYTES_DEF
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tefh_pkg::rsp_t out_rsp
);

  logic [31:0] exp_off;
  assign exp_off = 32'(out_rsp.block_index) * 32'(CHUNK_BYTES) + 32'(HEADER_BYTES);

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // failures carry no location
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != tefh_pkg::ST_OK |->
    out_rsp.block_index == '0 && out_rsp.data_offset == '0)
    else $error("failed request carries a location");

  // offset follows the block index
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.block_index != '0 |->
    out_rsp.data_offset == exp_off[tefh_pkg::OFFSET_W-1:0])
    else $error("data offset does not match block index");

endmodule

bind two_ended_first_fit_heap_core tefh_chk #(
  .CHUNK_BYTES  (CHUNK_BYTES),
  .HEADER_BYTES (HEADER_BYTES)
) u_tefh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);
